/* src/bgi_pkg.sv */
package bgi_pkg;

  localparam int CoordW   = 32;
  localparam int FracBits = 16;
  localparam int DiffW    = CoordW + 1;
  localparam int NumCfg   = 5;
  localparam int NumRatio = 6;
  localparam int AddrW    = 6;

  localparam logic signed [63:0] I64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] I64Min = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    RegRow0X = 3'd0,
    RegRow1X = 3'd1,
    RegRowY  = 3'd2,
    RegRow0Z = 3'd3,
    RegRow1Z = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RatIdle,
    RatDiv,
    RatStore
  } rat_state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] x3;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] y3;
    logic signed [CoordW-1:0] z0;
    logic signed [CoordW-1:0] z1;
    logic signed [CoordW-1:0] z2;
    logic signed [CoordW-1:0] z3;
  } cell_t;

  typedef struct packed {
    logic [NumRatio-1:0][63:0] mag;
    logic [NumRatio-1:0]       neg;
    logic                      busy;
  } ratio_t;

  typedef struct packed {
    logic signed [63:0] v;
    logic               sat;
  } sres_t;

  function automatic sres_t apply_sign(input logic [63:0] m, input logic neg);
    sres_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (m > 64'h8000_0000_0000_0000) begin
        r.sat = 1'b1;
        r.v   = I64Min;
      end else begin
        r.v = $signed(~m + 64'd1);
      end
    end else begin
      if (m > 64'h7FFF_FFFF_FFFF_FFFF) begin
        r.sat = 1'b1;
        r.v   = I64Max;
      end else begin
        r.v = $signed(m);
      end
    end
    return r;
  endfunction

  function automatic sres_t mul_fin(input logic [127:0] m, input logic neg,
                                    input logic [6:0] sh);
    logic [127:0] t;
    sres_t        r;
    t = m >> sh;
    if (t[127:64] != 64'd0) begin
      r.sat = 1'b1;
      r.v   = neg ? I64Min : I64Max;
    end else begin
      r = apply_sign(t[63:0], neg);
    end
    return r;
  endfunction

  function automatic sres_t sat_add(input logic signed [63:0] a,
                                    input logic signed [63:0] b);
    logic signed [64:0] s;
    sres_t              r;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      r.sat = 1'b1;
      r.v   = s[64] ? I64Min : I64Max;
    end else begin
      r.sat = 1'b0;
      r.v   = s[63:0];
    end
    return r;
  endfunction

endpackage

/* src/bgi_if.sv */
interface bgi_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] query_x;
  logic [31:0] query_y;

  modport source (output valid, output query_x, output query_y, input ready);
  modport sink (input valid, input query_x, input query_y, output ready);
endinterface

interface bgi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        degenerate;
  logic        saturated;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output degenerate, output saturated, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z,
                input degenerate, input saturated, output ready);
endinterface

/* src/bgi_ratio.sv */
module bgi_ratio (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  bgi_pkg::cell_t       cell_i,
  output bgi_pkg::ratio_t      ratio_o
);

  localparam int DW = bgi_pkg::DiffW;
  localparam int CW = bgi_pkg::CoordW;

  bgi_pkg::rat_state_e state_q, state_d;

  logic [2:0]    k_q;
  logic [5:0]    bit_q;
  logic [63:0]   num_q;
  logic [63:0]   quo_q;
  logic [CW:0]   rem_q;
  logic [DW-1:0] dmag_q;
  logic          neg_q;

  logic [bgi_pkg::NumRatio-1:0][63:0] rmag_q;
  logic [bgi_pkg::NumRatio-1:0]       rneg_q;

  logic                 load;
  logic                 store;
  logic [2:0]           ld_k;
  logic signed [DW-1:0] dd;
  logic signed [CW-1:0] zz;
  logic [CW-1:0]        zmag;
  logic [DW-1:0]        ld_dmag;
  logic [63:0]          ld_num;
  logic                 ld_neg;
  logic [CW+1:0]        trial;
  logic                 ge;
  logic [63:0]          clip;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bgi_pkg::RatIdle:  state_d = bgi_pkg::RatIdle;
      bgi_pkg::RatDiv:   if (&bit_q) state_d = bgi_pkg::RatStore;
      bgi_pkg::RatStore: begin
        if (k_q == 3'(bgi_pkg::NumRatio - 1)) state_d = bgi_pkg::RatIdle;
        else state_d = bgi_pkg::RatDiv;
      end
      default: state_d = bgi_pkg::RatIdle;
    endcase
    if (start_i) state_d = bgi_pkg::RatDiv;
  end

  always_comb begin
    store = (state_q == bgi_pkg::RatStore) && !start_i;
    load  = start_i || (store && (k_q != 3'(bgi_pkg::NumRatio - 1)));
    ld_k  = start_i ? 3'd0 : k_q + 3'd1;
  end

  always_comb begin
    zz = cell_i.z0;
    case (ld_k)
      3'd0: begin dd = DW'(cell_i.x0) - DW'(cell_i.x1); zz = cell_i.z0; end
      3'd1: begin dd = DW'(cell_i.x1) - DW'(cell_i.x0); zz = cell_i.z1; end
      3'd2: begin dd = DW'(cell_i.x2) - DW'(cell_i.x3); zz = cell_i.z2; end
      3'd3: begin dd = DW'(cell_i.x3) - DW'(cell_i.x2); zz = cell_i.z3; end
      3'd4: dd = DW'(cell_i.y0) - DW'(cell_i.y3);
      default: dd = DW'(cell_i.y3) - DW'(cell_i.y0);
    endcase
    zmag    = zz[CW-1] ? CW'(-zz) : CW'(zz);
    ld_dmag = dd[DW-1] ? DW'(-dd) : DW'(dd);
    if (ld_k < 3'd4) begin
      ld_num = 64'(zmag) << 32;
      ld_neg = zz[CW-1] ^ dd[DW-1];
    end else begin
      ld_num = 64'd1 << (bgi_pkg::FracBits + 32);
      ld_neg = dd[DW-1];
    end
  end

  always_comb begin
    trial = {rem_q, num_q[63]};
    ge    = trial >= (CW+2)'(dmag_q);
    if (neg_q) clip = (quo_q > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : quo_q;
    else       clip = (quo_q > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bgi_pkg::RatIdle;
      rmag_q  <= '0;
      rneg_q  <= '0;
    end else begin
      state_q <= state_d;
      if (store) begin
        rmag_q[k_q] <= clip;
        rneg_q[k_q] <= neg_q && (quo_q != 64'd0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      k_q    <= ld_k;
      bit_q  <= '0;
      num_q  <= ld_num;
      quo_q  <= '0;
      rem_q  <= '0;
      dmag_q <= ld_dmag;
      neg_q  <= ld_neg;
    end else if (state_q == bgi_pkg::RatDiv) begin
      bit_q <= bit_q + 6'd1;
      num_q <= {num_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], ge};
      rem_q <= ge ? (CW+1)'(trial - (CW+2)'(dmag_q)) : (CW+1)'(trial);
    end
  end

  assign ratio_o.mag  = rmag_q;
  assign ratio_o.neg  = rneg_q;
  assign ratio_o.busy = (state_q != bgi_pkg::RatIdle) || start_i;

endmodule

/* src/bgi_core.sv */
module bgi_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bgi_pkg::cell_t  cell_i,
  input  bgi_pkg::ratio_t ratio_i,
  bgi_in_if.sink          in_if,
  bgi_out_if.source       out_if
);

  localparam int DW   = bgi_pkg::DiffW;
  localparam int CW   = bgi_pkg::CoordW;
  localparam int NStg = 9;
  localparam logic signed [63:0] ZMax = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] ZMin = -ZMax - 64'sd1;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] adv;
  logic [31:0]     px_q [NStg];
  logic [31:0]     py_q [NStg];

  // stage 0: differences
  logic [DW-1:0] am_q [6];
  logic [5:0]    an_q;
  // stage 1: partial products
  logic [DW+31:0] pl_q [6];
  logic [DW+31:0] ph_q [6];
  logic [5:0]     pn_q;
  // stage 2: scaled products
  logic signed [63:0] m_q [6];
  logic               sat2_q;
  // stage 3: row sums and weights
  logic signed [63:0] t1_q, t2_q, wa_q, wb_q;
  logic               sat3_q;
  // stage 4: magnitudes
  logic [63:0] em_q [4];
  logic [1:0]  en_q;
  logic        sat4_q;
  // stage 5: 32x32 partials
  logic [63:0] pp_q [2][4];
  logic [1:0]  en5_q;
  logic        sat5_q;
  // stage 6: full products
  logic [127:0] sum_q [2];
  logic [1:0]   en6_q;
  logic         sat6_q;
  // stage 7: scaled blend terms
  logic signed [63:0] fm_q [2];
  logic               sat7_q;
  // stage 8: output
  logic [31:0] z_q;
  logic        deg_q;
  logic        sat8_q;

  logic signed [CW-1:0] qx, qy;
  logic signed [DW-1:0] dif [6];
  logic                 degen;

  always_comb begin
    adv[NStg-1] = !v_q[NStg-1] || out_if.ready;
    for (int i = NStg - 2; i >= 0; i--) adv[i] = !v_q[i] || adv[i+1];
  end

  assign in_if.ready = adv[0] && !ratio_i.busy;
  assign degen = (cell_i.x0 == cell_i.x1) || (cell_i.x2 == cell_i.x3) ||
                 (cell_i.y0 == cell_i.y3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_if.valid && !ratio_i.busy;
      for (int i = 1; i < NStg; i++) if (adv[i]) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      px_q[0] <= in_if.query_x;
      py_q[0] <= in_if.query_y;
    end
    for (int i = 1; i < NStg; i++) begin
      if (adv[i]) begin
        px_q[i] <= px_q[i-1];
        py_q[i] <= py_q[i-1];
      end
    end
  end

  always_comb begin
    qx     = $signed(in_if.query_x[CW-1:0]);
    qy     = $signed(in_if.query_y[CW-1:0]);
    dif[0] = DW'(qx) - DW'(cell_i.x1);
    dif[1] = DW'(qx) - DW'(cell_i.x0);
    dif[2] = DW'(qx) - DW'(cell_i.x3);
    dif[3] = DW'(qx) - DW'(cell_i.x2);
    dif[4] = DW'(qy) - DW'(cell_i.y3);
    dif[5] = DW'(qy) - DW'(cell_i.y0);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int k = 0; k < 6; k++) begin
        am_q[k] <= dif[k][DW-1] ? DW'(-dif[k]) : DW'(dif[k]);
        an_q[k] <= dif[k][DW-1];
      end
    end
    if (adv[1]) begin
      for (int k = 0; k < 6; k++) begin
        pl_q[k] <= (DW+32)'(am_q[k]) * (DW+32)'(ratio_i.mag[k][31:0]);
        ph_q[k] <= (DW+32)'(am_q[k]) * (DW+32)'(ratio_i.mag[k][63:32]);
        pn_q[k] <= an_q[k] ^ ratio_i.neg[k];
      end
    end
  end

  bgi_pkg::sres_t mr [6];
  logic           sat2_d;

  always_comb begin
    sat2_d = 1'b0;
    for (int k = 0; k < 6; k++) begin
      mr[k] = bgi_pkg::mul_fin((128'(ph_q[k]) << 32) + 128'(pl_q[k]), pn_q[k],
                               (k < 4) ? 7'd32 : 7'(bgi_pkg::FracBits));
      sat2_d = sat2_d | mr[k].sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int k = 0; k < 6; k++) m_q[k] <= mr[k].v;
      sat2_q <= sat2_d;
    end
  end

  bgi_pkg::sres_t s1, s2;

  always_comb begin
    s1 = bgi_pkg::sat_add(m_q[0], m_q[1]);
    s2 = bgi_pkg::sat_add(m_q[2], m_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      t1_q   <= s1.v;
      t2_q   <= s2.v;
      wa_q   <= m_q[4];
      wb_q   <= m_q[5];
      sat3_q <= sat2_q | s1.sat | s2.sat;
    end
    if (adv[4]) begin
      em_q[0] <= t1_q[63] ? 64'(-t1_q) : 64'(t1_q);
      em_q[1] <= wa_q[63] ? 64'(-wa_q) : 64'(wa_q);
      em_q[2] <= t2_q[63] ? 64'(-t2_q) : 64'(t2_q);
      em_q[3] <= wb_q[63] ? 64'(-wb_q) : 64'(wb_q);
      en_q    <= {t2_q[63] ^ wb_q[63], t1_q[63] ^ wa_q[63]};
      sat4_q  <= sat3_q;
    end
    if (adv[5]) begin
      for (int p = 0; p < 2; p++) begin
        pp_q[p][0] <= 64'(em_q[2*p][31:0])  * 64'(em_q[2*p+1][31:0]);
        pp_q[p][1] <= 64'(em_q[2*p][31:0])  * 64'(em_q[2*p+1][63:32]);
        pp_q[p][2] <= 64'(em_q[2*p][63:32]) * 64'(em_q[2*p+1][31:0]);
        pp_q[p][3] <= 64'(em_q[2*p][63:32]) * 64'(em_q[2*p+1][63:32]);
      end
      en5_q  <= en_q;
      sat5_q <= sat4_q;
    end
    if (adv[6]) begin
      for (int p = 0; p < 2; p++) begin
        sum_q[p] <= 128'(pp_q[p][0]) + (128'(pp_q[p][1]) << 32) +
                    (128'(pp_q[p][2]) << 32) + (128'(pp_q[p][3]) << 64);
      end
      en6_q  <= en5_q;
      sat6_q <= sat5_q;
    end
  end

  bgi_pkg::sres_t f0, f1, zs;
  logic signed [63:0] zc;
  logic               zsat;

  always_comb begin
    f0 = bgi_pkg::mul_fin(sum_q[0], en6_q[0], 7'd32);
    f1 = bgi_pkg::mul_fin(sum_q[1], en6_q[1], 7'd32);
    zs = bgi_pkg::sat_add(fm_q[0], fm_q[1]);
    zsat = sat7_q | zs.sat;
    zc   = zs.v;
    if (zs.v > ZMax) begin
      zc   = ZMax;
      zsat = 1'b1;
    end else if (zs.v < ZMin) begin
      zc   = ZMin;
      zsat = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      fm_q[0] <= f0.v;
      fm_q[1] <= f1.v;
      sat7_q  <= sat6_q | f0.sat | f1.sat;
    end
    if (adv[8]) begin
      deg_q  <= degen;
      z_q    <= degen ? 32'd0 : 32'($signed(zc[CW-1:0]));
      sat8_q <= degen ? 1'b0 : zsat;
    end
  end

  assign out_if.valid      = v_q[NStg-1];
  assign out_if.out_x      = px_q[NStg-1];
  assign out_if.out_y      = py_q[NStg-1];
  assign out_if.out_z      = z_q;
  assign out_if.degenerate = deg_q;
  assign out_if.saturated  = sat8_q;

endmodule

/* src/bilinear_grid_interpolator.sv */
// channel  dir  handshake      beat contents
// in_if    in   valid/ready    query_x, query_y
// out_if   out  valid/ready    out_x, out_y, out_z, degenerate, saturated
// apb      in   psel/penable   64-bit registers at 8*i, write and read
//
// One beat per cycle sustained while out_if is ready and the divider is idle.
// Each valid register write reruns the ratio divider: a registered start, then
// 6 divides, during which in_if.ready is low.
// A stall on out_if backs up stage by stage; bubbles still fill.
// Reset clears registers and ratios; the cell reads as degenerate.
module bilinear_grid_interpolator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bgi_in_if.sink                      in_if,
  bgi_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bgi_pkg::AddrW-1:0]   paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);

  localparam int CW = bgi_pkg::CoordW;

  logic [63:0]    cfg_q [bgi_pkg::NumCfg];
  logic [2:0]     idx;
  logic           wr;
  logic           start_q;
  bgi_pkg::cell_t cell_cfg;
  bgi_pkg::ratio_t ratio;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite && (idx < 3'(bgi_pkg::NumCfg));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bgi_pkg::NumCfg; i++) cfg_q[i] <= '0;
    end else if (wr) begin
      cfg_q[idx] <= pwdata;
    end
  end

  // divider starts once the written value is visible
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= wr;
    end
  end

  assign prdata = (idx < 3'(bgi_pkg::NumCfg)) ? cfg_q[idx] : 64'd0;

  always_comb begin
    cell_cfg.x0 = cfg_q[bgi_pkg::RegRow0X][CW-1:0];
    cell_cfg.x1 = cfg_q[bgi_pkg::RegRow0X][32+CW-1:32];
    cell_cfg.x2 = cfg_q[bgi_pkg::RegRow1X][CW-1:0];
    cell_cfg.x3 = cfg_q[bgi_pkg::RegRow1X][32+CW-1:32];
    cell_cfg.y0 = cfg_q[bgi_pkg::RegRowY][CW-1:0];
    cell_cfg.y3 = cfg_q[bgi_pkg::RegRowY][32+CW-1:32];
    cell_cfg.z0 = cfg_q[bgi_pkg::RegRow0Z][CW-1:0];
    cell_cfg.z1 = cfg_q[bgi_pkg::RegRow0Z][32+CW-1:32];
    cell_cfg.z2 = cfg_q[bgi_pkg::RegRow1Z][CW-1:0];
    cell_cfg.z3 = cfg_q[bgi_pkg::RegRow1Z][32+CW-1:32];
  end

  bgi_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .cell_i  (cell_cfg),
    .ratio_o (ratio)
  );

  bgi_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cell_i  (cell_cfg),
    .ratio_i (ratio),
    .in_if   (in_if),
    .out_if  (out_if)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import bgi_pkg::*;

  typedef struct {
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] z;
    logic        degen;
    logic        sat;
  } interp_beat_t;

  class interp_scoreboard;
    logic [63:0]        regs[NumCfg];
    logic signed [63:0] ratio[NumRatio];
    bit                 degen;
    bit                 clip;
    int                 errors;
    interp_beat_t       pending[$];

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (ratio[i]) ratio[i] = '0;
      degen = 1'b1;
      errors = 0;
    endfunction

    function logic [63:0] magnitude(logic signed [63:0] v);
      return v < 0 ? 64'd0 - v : v;
    endfunction

    function logic signed [63:0] signed_clip(logic [63:0] m, bit neg);
      if (neg) begin
        if (m > 64'h8000_0000_0000_0000) begin
          clip = 1'b1;
          return I64Min;
        end
        return $signed(64'd0 - m);
      end
      if (m > 64'h7FFF_FFFF_FFFF_FFFF) begin
        clip = 1'b1;
        return I64Max;
      end
      return $signed(m);
    endfunction

    function logic signed [63:0] mul_trunc(logic signed [63:0] a, logic signed [63:0] b,
                                           int s);
      logic [127:0] p;
      bit           neg;
      neg = (a < 0) != (b < 0);
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      p = p >> s;
      if (p[127:64] != 0) begin
        clip = 1'b1;
        return neg ? I64Min : I64Max;
      end
      return signed_clip(p[63:0], neg);
    endfunction

    function logic signed [63:0] add_clip(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
        clip = 1'b1;
        return s[64] ? I64Min : I64Max;
      end
      return s[63:0];
    endfunction

    function logic signed [63:0] slot(cfg_reg_e r, bit hi);
      logic signed [31:0] v;
      v = hi ? regs[r][63:32] : regs[r][31:0];
      return v;
    endfunction

    function logic signed [63:0] quotient(logic [63:0] num, bit neg, logic signed [63:0] d);
      bit                 keep;
      logic signed [63:0] q;
      keep = clip;
      q = signed_clip(num / magnitude(d), neg != (d < 0));
      clip = keep;
      return q;
    endfunction

    function void write_reg(cfg_reg_e r, logic [63:0] v);
      logic signed [63:0] x0, x1, x2, x3, y0, y3;
      logic signed [63:0] zc[4];
      logic signed [63:0] dx[4];
      regs[r] = v;
      x0 = slot(RegRow0X, 0); x1 = slot(RegRow0X, 1);
      x2 = slot(RegRow1X, 0); x3 = slot(RegRow1X, 1);
      y0 = slot(RegRowY, 0);  y3 = slot(RegRowY, 1);
      zc[0] = slot(RegRow0Z, 0); zc[1] = slot(RegRow0Z, 1);
      zc[2] = slot(RegRow1Z, 0); zc[3] = slot(RegRow1Z, 1);
      dx[0] = x0 - x1; dx[1] = x1 - x0; dx[2] = x2 - x3; dx[3] = x3 - x2;
      degen = (dx[0] == 0) || (dx[2] == 0) || (y0 == y3);
      foreach (ratio[i]) ratio[i] = '0;
      if (!degen) begin
        for (int k = 0; k < 4; k++)
          ratio[k] = quotient(magnitude(zc[k]) << 32, zc[k] < 0, dx[k]);
        ratio[4] = quotient(64'd1 << (FracBits + 32), 1'b0, y0 - y3);
        ratio[5] = quotient(64'd1 << (FracBits + 32), 1'b0, y3 - y0);
      end
    endfunction

    function void note_query(logic [31:0] qx, logic [31:0] qy);
      interp_beat_t       e;
      logic signed [63:0] x, y, t1, t2, wa, wb, zv;
      clip = 1'b0;
      zv = 0;
      if (!degen) begin
        x = $signed(qx);
        y = $signed(qy);
        t1 = add_clip(mul_trunc(x - slot(RegRow0X, 1), ratio[0], 32),
                      mul_trunc(x - slot(RegRow0X, 0), ratio[1], 32));
        t2 = add_clip(mul_trunc(x - slot(RegRow1X, 1), ratio[2], 32),
                      mul_trunc(x - slot(RegRow1X, 0), ratio[3], 32));
        wa = mul_trunc(y - slot(RegRowY, 1), ratio[4], FracBits);
        wb = mul_trunc(y - slot(RegRowY, 0), ratio[5], FracBits);
        zv = add_clip(mul_trunc(t1, wa, 32), mul_trunc(t2, wb, 32));
        if (zv > 64'sh7FFF_FFFF) begin
          zv = 64'sh7FFF_FFFF;
          clip = 1'b1;
        end
        if (zv < -64'sh8000_0000) begin
          zv = -64'sh8000_0000;
          clip = 1'b1;
        end
      end
      e.qx = qx; e.qy = qy; e.z = zv[31:0]; e.degen = degen; e.sat = clip;
      pending.push_back(e);
    endfunction

    function void check_result(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                               logic dg, logic st);
      interp_beat_t e;
      if (pending.size() == 0) begin
        $error("result beat with no query outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (ox !== e.qx) begin
        $error("out_x expected %h got %h", e.qx, ox);
        errors++;
      end
      if (oy !== e.qy) begin
        $error("out_y expected %h got %h", e.qy, oy);
        errors++;
      end
      if (oz !== e.z) begin
        $error("out_z expected %h got %h", e.z, oz);
        errors++;
      end
      if (dg !== e.degen) begin
        $error("degenerate expected %b got %b", e.degen, dg);
        errors++;
      end
      if (st !== e.sat) begin
        $error("saturated expected %b got %b", e.sat, st);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel, penable, pwrite, pready;
  logic [AddrW-1:0]  paddr;
  logic [63:0]       pwdata, prdata;
  bit                calm;
  interp_scoreboard  sb;

  bgi_in_if  in_if ();
  bgi_out_if out_if ();

  bilinear_grid_interpolator DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    #3ms;
    $display("FAIL bilinear_grid_interpolator");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.out_x, out_if.out_y, out_if.out_z,
                        out_if.degenerate, out_if.saturated);
      if (in_if.valid && in_if.ready)
        sb.note_query(in_if.query_x, in_if.query_y);
    end
  end

  always @(posedge clk_i)
    out_if.ready <= calm || ($urandom_range(0, 99) >= 21);

  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [63:0] v);
    int n;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrW'(8 * int'(r)); pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.write_reg(r, v);
    n = 0;
    while (in_if.ready && n < 4) begin
      @(posedge clk_i);
      n++;
    end
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic program_cell(logic [31:0] x0, x1, x2, x3, y0, y3, z0, z1, z2, z3);
    wait_idle();
    write_reg(RegRow0X, {x1, x0});
    write_reg(RegRow1X, {x3, x2});
    write_reg(RegRowY, {y3, y0});
    write_reg(RegRow0Z, {z1, z0});
    write_reg(RegRow1Z, {z3, z2});
  endtask

  task automatic send_query(logic [31:0] qx, logic [31:0] qy);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.query_x <= qx;
    in_if.query_y <= qy;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic end_burst();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_span(int bits);
    logic [31:0] v;
    v = $urandom;
    return $signed(v) >>> (32 - bits);
  endfunction

  task automatic random_queries(int n, logic [31:0] cx, logic [31:0] cy);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 70)
        send_query(cx + rnd_span($urandom_range(4, 24)), cy + rnd_span($urandom_range(4, 24)));
      else
        send_query($urandom, $urandom);
    end
    end_burst();
  endtask

  task automatic random_cell(int n);
    logic [31:0] x0, x1, x2, x3, y0, y3;
    int          sp;
    sp = $urandom_range(8, 26);
    x0 = rnd_span(sp); x1 = x0 + rnd_span(sp); x2 = rnd_span(sp); x3 = x2 + rnd_span(sp);
    y0 = rnd_span(sp); y3 = y0 + rnd_span(sp);
    if ($urandom_range(0, 3) == 0)
      program_cell($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
    else
      program_cell(x0, x1, x2, x3, y0, y3, rnd_span($urandom_range(8, 32)),
                   rnd_span($urandom_range(8, 32)), rnd_span($urandom_range(8, 32)),
                   rnd_span($urandom_range(8, 32)));
    random_queries(n, x0, y0);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    calm = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.query_x = '0; in_if.query_y = '0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);

    // reset cell reads degenerate
    send_query(32'h0, 32'h0);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'hFFFF_FFFF, 32'h0000_0001);
    end_burst();

    // unit cell
    program_cell(32'h0, 32'h1_0000, 32'h0, 32'h1_0000, 32'h0, 32'h1_0000,
                 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000);
    send_query(32'h0, 32'h0);
    send_query(32'h1_0000, 32'h0);
    send_query(32'h0, 32'h1_0000);
    send_query(32'h1_0000, 32'h1_0000);
    send_query(32'h8000, 32'h8000);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h8000_0000, 32'h8000_0000);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'hFFFF_8000, 32'h0002_8000);
    send_query(32'h0000_0001, 32'hFFFF_FFFF);
    end_burst();

    // extreme coordinates and values
    program_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h0, 32'h0);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    end_burst();
    random_queries(120, 32'h0, 32'h0);

    // one-lsb row spacing, overflow inside the blend
    program_cell(32'h0, 32'h1, 32'h0, 32'h1, 32'h0, 32'h1,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    random_queries(100, 32'h0, 32'h0);

    // flat rows in y
    program_cell(32'h0, 32'h2_0000, 32'h0, 32'h2_0000, 32'h5_0000, 32'h5_0000,
                 32'h1, 32'h2, 32'h3, 32'h4);
    random_queries(40, 32'h0, 32'h5_0000);

    // collapsed upper row in x
    program_cell(32'h0, 32'h2_0000, 32'h3_0000, 32'h3_0000, 32'h0, 32'h1_0000,
                 32'h1, 32'h2, 32'h3, 32'h4);
    random_queries(40, 32'h3_0000, 32'h0);

    for (int p = 0; p < 7; p++) begin
      calm = (p == 3);
      random_cell(200);
    end
    calm = 1'b0;

    wait_idle();
    if (sb.errors == 0)
      $display("PASS bilinear_grid_interpolator");
    else
      $display("FAIL bilinear_grid_interpolator");
    $finish;
  end

endmodule

/* filelist.f */
src/bgi_pkg.sv
src/bgi_if.sv
src/bgi_ratio.sv
src/bgi_core.sv
src/bilinear_grid_interpolator.sv
verif/testbench.sv
